>>> rtl/cbf_pkg.sv
// Shared types for the cubic Bezier curve flattener.
// Holds the sequencer state encoding and the divider status bundle.
// No dependencies; used by cbf_div and cubic_bezier_curve_flattener.
`timescale 1ns / 1ps
`default_nettype none

package cbf_pkg;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEN  = 6'b000010,
    S_COEF = 6'b000100,
    S_ACC  = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_stat_t;

  localparam logic [5:0] SEG_COUNT_RESET = 6'd32;

endpackage

`default_nettype wire

>>> rtl/cbf_mul.sv
// Shared registered multiplier: unsigned coefficient times signed operand.
// One product per cycle, registered: available in the cycle after the operands.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cbf_mul #(
  parameter int AW = 18,
  parameter int BW = 16
) (
  input  wire logic                 clk,
  input  wire logic [AW-1:0]        a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [AW+BW:0]     prod
);

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, a}) * b;
  end

endmodule

`default_nettype wire

>>> rtl/cbf_div.sv
// Restoring divider, one quotient bit per cycle, with overflow detection.
// Quotient has QB bits; ovf flags a quotient that would not fit.
// Depends on cbf_pkg for the status bundle.
`timescale 1ns / 1ps
`default_nettype none

module cbf_div #(
  parameter int DW = 35,
  parameter int VW = 18,
  parameter int QB = 15
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic [QB-1:0]      quot,
  output cbf_pkg::div_stat_t stat
);

  localparam int CNTW = $clog2(QB + 1);

  logic [DW-1:0]   rem;
  logic [DW-1:0]   dsh;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done;
  logic            ovf;
  logic            ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(QB);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dsh  <= DW'(divisor) << (QB - 1);
      quot <= '0;
      ovf  <= dividend >= (DW'(divisor) << QB);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quot <= QB'({quot, ge});
      dsh  <= dsh >> 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.ovf  = ovf;

endmodule

`default_nettype wire

>>> rtl/cubic_bezier_curve_flattener.sv
// Top level of the cubic Bezier curve flattener: sequencer and datapath registers.
// Instantiates cbf_mul (shared multiplier) and cbf_div (iterative divider).
// Depends on cbf_pkg.
//
//   channel  | direction | handshake                    | payload
//   s_axis   | in        | s_axis_tvalid/s_axis_tready  | s_axis_tdata: 8 control coordinates
//   m_axis   | out       | m_axis_tvalid/m_axis_tready  | m_axis_tdata, m_axis_tlast
//   cfg      | in        | cfg_valid/cfg_ready          | cfg_data: segment count
//
// Each point needs six coefficient multiplies, four multiply-accumulates per axis, and a
// COORD_BITS-1 step division per axis, all through the one multiplier and one divider.
// Reset returns the sequencer to idle and the segment count to 32; no clearing pass.
// A stalled output holds the finished point while the next point is computed.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_curve_flattener #(
  parameter int MAX_SEGMENTS = 63,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
  input  wire logic [8*COORD_BITS-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // point_x, point_y, zero fill
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic                             m_axis_tlast,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [5:0]                  cfg_data
);

  localparam int IW  = $clog2(MAX_SEGMENTS + 1);
  localparam int CW  = 3 * IW;
  localparam int PW  = CW + COORD_BITS + 1;
  localparam int QB  = COORD_BITS - 1;
  localparam int ODW = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam logic [QB-1:0]         ONE_Q = QB'(1) << (COORD_BITS - 2);
  localparam logic [COORD_BITS-1:0] ONE_C = COORD_BITS'(1) << (COORD_BITS - 2);

  cbf_pkg::state_t    state;
  cbf_pkg::div_stat_t div_stat;

  logic [5:0]                   seg_count;
  logic [2:0]                   op;
  logic                         axis;
  logic [IW-1:0]                step;
  logic [IW-1:0]                n_seg;
  logic [IW-1:0]                n_clamped;
  logic [IW-1:0]                u_val;
  logic [COORD_BITS-1:0]        held [8];
  logic [CW-1:0]                coef [4];
  logic [CW-1:0]                den;
  logic [CW-1:0]                usq;
  logic [CW-1:0]                isq;
  logic [CW-1:0]                triple;
  logic signed [PW-1:0]         acc;
  logic [PW-1:0]                acc_mag;
  logic [PW-1:0]                dividend;
  logic                         neg;
  logic [QB-1:0]                div_quot;
  logic                         over;
  logic [COORD_BITS-1:0]        res_mag;
  logic [COORD_BITS-1:0]        res_val;
  logic [COORD_BITS-1:0]        px;
  logic [COORD_BITS-1:0]        py;
  logic [COORD_BITS-1:0]        out_x;
  logic [COORD_BITS-1:0]        out_y;
  logic [CW-1:0]                mul_a;
  logic signed [COORD_BITS-1:0] mul_b;
  logic signed [PW-1:0]         prod;
  logic                         accept;
  logic                         out_free;
  logic                         out_load;
  logic                         is_last;
  logic                         div_start;

  assign s_axis_tready = (state == cbf_pkg::S_IDLE);
  assign cfg_ready     = 1'b1;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign out_load      = (state == cbf_pkg::S_OUT) & out_free;
  assign is_last       = (step == n_seg);
  assign div_start     = (state == cbf_pkg::S_ACC) & (op == 3'd5);
  assign u_val         = n_seg - step;
  assign triple        = prod[CW-1:0] + {prod[CW-2:0], 1'b0};
  assign acc_mag       = acc[PW-1] ? PW'(-acc) : PW'(acc);
  assign dividend      = acc_mag + PW'(den >> 1);
  assign over          = div_stat.ovf | (div_quot > ONE_Q);
  assign res_mag       = over ? ONE_C : COORD_BITS'(div_quot);
  assign res_val       = neg ? (~res_mag + COORD_BITS'(1)) : res_mag;
  assign m_axis_tdata  = ODW'({out_y, out_x});

  always_comb begin
    if (seg_count == 6'd0) begin
      n_clamped = IW'(1);
    end else if (seg_count > 6'(MAX_SEGMENTS)) begin
      n_clamped = IW'(MAX_SEGMENTS);
    end else begin
      n_clamped = IW'(seg_count);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      cbf_pkg::S_DEN: begin
        if (op == 3'd0) begin
          mul_a = CW'(n_seg);
          mul_b = COORD_BITS'(n_seg);
        end else if (op == 3'd1) begin
          mul_a = prod[CW-1:0];
          mul_b = COORD_BITS'(n_seg);
        end
      end
      cbf_pkg::S_COEF: begin
        case (op)
          3'd0: begin
            mul_a = CW'(u_val);
            mul_b = COORD_BITS'(u_val);
          end
          3'd1: begin
            mul_a = CW'(step);
            mul_b = COORD_BITS'(step);
          end
          3'd2: begin
            mul_a = usq;
            mul_b = COORD_BITS'(u_val);
          end
          3'd3: begin
            mul_a = isq;
            mul_b = COORD_BITS'(step);
          end
          3'd4: begin
            mul_a = usq;
            mul_b = COORD_BITS'(step);
          end
          3'd5: begin
            mul_a = isq;
            mul_b = COORD_BITS'(u_val);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      cbf_pkg::S_ACC: begin
        if (op < 3'd4) begin
          mul_a = coef[op[1:0]];
          mul_b = held[{op[1:0], axis}];
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cbf_pkg::S_IDLE;
      op            <= '0;
      axis          <= 1'b0;
      step          <= '0;
      m_axis_tvalid <= 1'b0;
      seg_count     <= cbf_pkg::SEG_COUNT_RESET;
    end else begin
      if (cfg_valid & cfg_ready) begin
        seg_count <= cfg_data;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        cbf_pkg::S_IDLE: begin
          if (accept) begin
            state <= cbf_pkg::S_DEN;
            op    <= '0;
            step  <= '0;
          end
        end
        cbf_pkg::S_DEN: begin
          if (op == 3'd2) begin
            state <= cbf_pkg::S_COEF;
            op    <= '0;
          end else begin
            op <= op + 3'd1;
          end
        end
        cbf_pkg::S_COEF: begin
          if (op == 3'd6) begin
            state <= cbf_pkg::S_ACC;
            op    <= '0;
            axis  <= 1'b0;
          end else begin
            op <= op + 3'd1;
          end
        end
        cbf_pkg::S_ACC: begin
          if (op == 3'd5) begin
            state <= cbf_pkg::S_DIV;
            op    <= '0;
          end else begin
            op <= op + 3'd1;
          end
        end
        cbf_pkg::S_DIV: begin
          if (div_stat.done) begin
            if (!axis) begin
              axis  <= 1'b1;
              state <= cbf_pkg::S_ACC;
            end else begin
              state <= cbf_pkg::S_OUT;
            end
          end
        end
        cbf_pkg::S_OUT: begin
          if (out_free) begin
            op <= '0;
            if (is_last) begin
              state <= cbf_pkg::S_IDLE;
              step  <= '0;
            end else begin
              state <= cbf_pkg::S_COEF;
              step  <= step + IW'(1);
            end
          end
        end
        default: begin
          state <= cbf_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 8; k++) begin
        held[k] <= s_axis_tdata[k*COORD_BITS +: COORD_BITS];
      end
      n_seg <= n_clamped;
    end
    if (state == cbf_pkg::S_DEN && op == 3'd2) begin
      den <= prod[CW-1:0];
    end
    if (state == cbf_pkg::S_COEF) begin
      case (op)
        3'd1: usq <= prod[CW-1:0];
        3'd2: isq <= prod[CW-1:0];
        3'd3: coef[0] <= prod[CW-1:0];
        3'd4: coef[3] <= prod[CW-1:0];
        3'd5: coef[1] <= triple;
        3'd6: coef[2] <= triple;
        default: ;
      endcase
    end
    if (state == cbf_pkg::S_ACC) begin
      if (op == 3'd1) begin
        acc <= prod;
      end else if (op == 3'd2 || op == 3'd3 || op == 3'd4) begin
        acc <= acc + prod;
      end
    end
    if (div_start) begin
      neg <= acc[PW-1];
    end
    if (state == cbf_pkg::S_DIV && div_stat.done) begin
      if (!axis) begin
        px <= res_val;
      end else begin
        py <= res_val;
      end
    end
    if (out_load) begin
      out_x        <= px;
      out_y        <= py;
      m_axis_tlast <= is_last;
    end
  end

  cbf_mul #(
    .AW(CW),
    .BW(COORD_BITS)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  cbf_div #(
    .DW(PW),
    .VW(CW),
    .QB(QB)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dividend),
    .divisor (den),
    .quot    (div_quot),
    .stat    (div_stat)
  );

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("Division started while the divider is busy.");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == cbf_pkg::S_DIV))
    else $error("Divider finished outside the division state.");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state != cbf_pkg::S_IDLE && state != cbf_pkg::S_DEN) |-> (step <= n_seg))
    else $error("Point counter ran past the segment count.");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && is_last) |=> (state == cbf_pkg::S_IDLE && m_axis_tlast))
    else $error("Final point did not return the sequencer to idle.");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == cbf_pkg::S_ACC) |-> (den != '0))
    else $error("Divisor is zero during accumulation.");

endmodule

`default_nettype wire
